FILE: rtl/core/sdt_pkg.sv
// sdt_pkg: shared types and constants of the distance table path mean unit
// request actions, controller states, controller command and status structs
// no dependencies
package sdt_pkg;

   localparam int IndexW     = 6;
   localparam int DistW      = 32;
   localparam int TriW       = 13;
   localparam int MaxIndices = 64;

   typedef enum logic [1:0] {
      ACT_STORE  = 2'd0,
      ACT_LOOKUP = 2'd1,
      ACT_PATH   = 2'd2,
      ACT_CLEAR  = 2'd3
   } action_type;

   localparam logic RESULT_LOOKUP = 1'b0;
   localparam logic RESULT_PATH   = 1'b1;

   typedef enum logic [2:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_EVAL,
      ST_DIV,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic take;
      logic eval;
      logic sweep;
      logic load_out;
   } ctrl_cmd_type;

   typedef struct packed {
      logic       req_valid;
      action_type action;
      logic       last;
      logic       sweep_done;
      logic       div_done;
      logic       out_free;
   } ctrl_status_type;

endpackage

FILE: rtl/core/sdt_if.sv
// sdt_req_if and sdt_rsp_if: valid/ready channels of the unit
// depends on sdt_pkg for field widths
interface sdt_req_if;
   logic                              valid;
   logic                              ready;
   logic [1:0]                        action;
   logic [sdt_pkg::IndexW-1:0]        first_index;
   logic [sdt_pkg::IndexW-1:0]        second_index;
   logic signed [sdt_pkg::DistW-1:0]  distance;
   logic                              last_in_path;

   modport source (output valid, action, first_index, second_index, distance,
                   last_in_path, input ready);
   modport sink (input valid, action, first_index, second_index, distance,
                 last_in_path, output ready);
endinterface

interface sdt_rsp_if;
   logic                              valid;
   logic                              ready;
   logic                              result_kind;
   logic                              found;
   logic signed [sdt_pkg::DistW-1:0]  value;
   logic                              overflow;

   modport source (output valid, result_kind, found, value, overflow, input ready);
   modport sink (input valid, result_kind, found, value, overflow, output ready);
endinterface

FILE: rtl/core/sdt_divider.sv
// sdt_divider: restoring divider, one quotient bit per cycle, truncates toward zero
// depends on sdt_pkg
module sdt_divider #(
   parameter int SumW = 48,
   parameter int CntW = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic signed [SumW-1:0]          dividend,
   input  logic [CntW-1:0]                 divisor,
   output logic                            done,
   output logic [sdt_pkg::DistW-1:0]       quotient
);

   localparam int StepW = $clog2(SumW + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [StepW-1:0]  step_ff, step_in;
   logic [SumW-1:0]   quo_ff, quo_in;
   logic [CntW-1:0]   rem_ff, rem_in;
   logic [CntW-1:0]   den_ff, den_in;
   logic              neg_ff, neg_in;
   logic [CntW:0]     trial;
   logic              ge;
   logic [SumW-1:0]   magnitude;
   logic [SumW-1:0]   signed_quo;

   assign magnitude = dividend[SumW-1] ? SumW'(-dividend) : SumW'(dividend);
   assign trial     = {rem_ff, quo_ff[SumW-1]};
   assign ge        = trial >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = StepW'(SumW);
         quo_in  = magnitude;
         rem_in  = '0;
         den_in  = divisor;
         neg_in  = dividend[SumW-1];
      end else if (busy_ff) begin
         quo_in  = {quo_ff[SumW-2:0], ge};
         rem_in  = ge ? CntW'(trial - {1'b0, den_ff}) : trial[CntW-1:0];
         step_in = step_ff - 1'b1;
         if (step_ff == StepW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   assign signed_quo = neg_ff ? SumW'(-quo_ff) : quo_ff;
   assign quotient   = signed_quo[sdt_pkg::DistW-1:0];
   assign done       = done_ff;

endmodule

FILE: rtl/core/sdt_datapath.sv
// sdt_datapath: triangular address, distance memory with valid mark, path
// accumulator, divider and result register; depends on sdt_pkg, sdt_divider
module sdt_datapath #(
   parameter int NUM_INDICES    = 64,
   parameter int MAX_PATH_PAIRS = 65535
) (
   input  logic                                clock,
   input  logic                                reset,
   input  sdt_pkg::ctrl_cmd_type               cmd,
   output sdt_pkg::ctrl_status_type            status,
   input  logic                                req_valid,
   input  logic [1:0]                          req_action,
   input  logic [sdt_pkg::IndexW-1:0]          req_first_index,
   input  logic [sdt_pkg::IndexW-1:0]          req_second_index,
   input  logic signed [sdt_pkg::DistW-1:0]    req_distance,
   input  logic                                req_last_in_path,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_result_kind,
   output logic                                rsp_found,
   output logic signed [sdt_pkg::DistW-1:0]    rsp_value,
   output logic                                rsp_overflow
);

   localparam int IndexW   = sdt_pkg::IndexW;
   localparam int DistW    = sdt_pkg::DistW;
   localparam int TriW     = sdt_pkg::TriW;
   localparam int Usable   = (NUM_INDICES < sdt_pkg::MaxIndices) ?
                             NUM_INDICES : sdt_pkg::MaxIndices;
   localparam int Depth    = Usable * (Usable + 1) / 2;
   localparam int AddrW    = $clog2(Depth);
   localparam int CntW     = $clog2(MAX_PATH_PAIRS + 1);
   localparam int SumW     = DistW + CntW;
   localparam logic [CntW-1:0]  MaxCount = CntW'(MAX_PATH_PAIRS);
   localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);

   sdt_pkg::action_type req_act;
   logic [IndexW-1:0]   pa, pb, lo, hi;
   logic                in_range;
   logic [TriW-1:0]     tri_full;
   logic [AddrW-1:0]    rd_addr;

   logic [DistW:0]      mem_ff [Depth];
   logic [DistW:0]      rdata_ff;
   logic                mem_we;
   logic [AddrW-1:0]    mem_waddr;
   logic [DistW:0]      mem_wdata;

   sdt_pkg::action_type action_ff;
   logic [IndexW-1:0]   index_ff;
   logic                last_ff;
   logic signed [DistW-1:0] dist_ff;
   logic [AddrW-1:0]    addr_ff;
   logic                in_range_ff;

   logic [AddrW-1:0]    sweep_cnt_ff;
   logic                sweep_done;

   logic [IndexW-1:0]   prev_index_ff;
   logic                have_prev_ff;
   logic signed [SumW-1:0] sum_ff, sum_in;
   logic [CntW-1:0]     cnt_ff, cnt_in;
   logic                ovf_ff, ovf_in;
   logic                hit, at_limit;
   logic                path_eval;

   logic                div_start, div_done;
   logic [CntW-1:0]     div_den;
   logic [DistW-1:0]    div_quo;

   logic                res_kind_ff, res_found_ff, res_ovf_ff;
   logic signed [DistW-1:0] res_value_ff;
   logic                lookup_found;

   logic                rsp_valid_ff;
   logic                rsp_kind_ff, rsp_found_ff, rsp_ovf_ff;
   logic signed [DistW-1:0] rsp_value_ff;

   // ordered pair and triangular address
   assign req_act  = sdt_pkg::action_type'(req_action);
   assign pa       = (req_act == sdt_pkg::ACT_PATH) ? prev_index_ff : req_first_index;
   assign pb       = (req_act == sdt_pkg::ACT_PATH) ? req_first_index : req_second_index;
   assign lo       = (pa < pb) ? pa : pb;
   assign hi       = (pa < pb) ? pb : pa;
   assign in_range = 32'(hi) < 32'(NUM_INDICES);
   assign tri_full = TriW'((TriW'(hi) * (TriW'(hi) + TriW'(1))) >> 1) + TriW'(lo);
   assign rd_addr  = in_range ? tri_full[AddrW-1:0] : '0;

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         action_ff   <= req_act;
         index_ff    <= req_first_index;
         last_ff     <= req_last_in_path;
         dist_ff     <= req_distance;
         addr_ff     <= rd_addr;
         in_range_ff <= in_range;
         rdata_ff    <= mem_ff[rd_addr];
      end
   end

   // distance memory, top bit is the valid mark
   assign mem_we    = cmd.sweep ||
                      (cmd.eval && action_ff == sdt_pkg::ACT_STORE && in_range_ff);
   assign mem_waddr = cmd.sweep ? sweep_cnt_ff : addr_ff;
   assign mem_wdata = cmd.sweep ? '0 : {1'b1, dist_ff};

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[mem_waddr] <= mem_wdata;
      end
   end

   assign sweep_done = cmd.sweep && (sweep_cnt_ff == LastAddr);

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_cnt_ff <= '0;
      end else if (cmd.sweep) begin
         sweep_cnt_ff <= sweep_done ? '0 : sweep_cnt_ff + 1'b1;
      end
   end

   // path accumulator
   assign path_eval = cmd.eval && action_ff == sdt_pkg::ACT_PATH;
   assign hit       = have_prev_ff && in_range_ff && rdata_ff[DistW];
   assign at_limit  = cnt_ff == MaxCount;

   always_comb begin
      sum_in = sum_ff;
      cnt_in = cnt_ff;
      ovf_in = ovf_ff;
      if (hit) begin
         if (at_limit) begin
            ovf_in = 1'b1;
         end else begin
            sum_in = sum_ff + SumW'($signed(rdata_ff[DistW-1:0]));
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_index_ff <= '0;
         have_prev_ff  <= 1'b0;
         sum_ff        <= '0;
         cnt_ff        <= '0;
         ovf_ff        <= 1'b0;
      end else if (path_eval) begin
         if (last_ff) begin
            prev_index_ff <= '0;
            have_prev_ff  <= 1'b0;
            sum_ff        <= '0;
            cnt_ff        <= '0;
            ovf_ff        <= 1'b0;
         end else begin
            prev_index_ff <= index_ff;
            have_prev_ff  <= 1'b1;
            sum_ff        <= sum_in;
            cnt_ff        <= cnt_in;
            ovf_ff        <= ovf_in;
         end
      end
   end

   // path mean, a count of zero divides by one
   assign div_start = path_eval && last_ff;
   assign div_den   = (cnt_in == '0) ? CntW'(1) : cnt_in;

   sdt_divider #(
      .SumW (SumW),
      .CntW (CntW)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_in),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (div_quo)
   );

   // result register
   assign lookup_found = in_range_ff && rdata_ff[DistW];

   always_ff @(posedge clock) begin
      if (cmd.eval && action_ff == sdt_pkg::ACT_LOOKUP) begin
         res_kind_ff  <= sdt_pkg::RESULT_LOOKUP;
         res_found_ff <= lookup_found;
         res_value_ff <= lookup_found ? $signed(rdata_ff[DistW-1:0]) : '0;
         res_ovf_ff   <= 1'b0;
      end else begin
         if (div_start) begin
            res_ovf_ff <= ovf_in;
         end
         if (div_done) begin
            res_kind_ff  <= sdt_pkg::RESULT_PATH;
            res_found_ff <= 1'b0;
            res_value_ff <= $signed(div_quo);
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_kind_ff  <= res_kind_ff;
         rsp_found_ff <= res_found_ff;
         rsp_value_ff <= res_value_ff;
         rsp_ovf_ff   <= res_ovf_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_value       = rsp_value_ff;
   assign rsp_overflow    = rsp_ovf_ff;

   assign status.req_valid  = req_valid;
   assign status.action     = action_ff;
   assign status.last       = last_ff;
   assign status.sweep_done = sweep_done;
   assign status.div_done   = div_done;
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

endmodule

FILE: rtl/core/sdt_controller.sv
// sdt_controller: sequencer for sweep, request evaluation, division and response
// depends on sdt_pkg
module sdt_controller (
   input  logic                       clock,
   input  logic                       reset,
   input  sdt_pkg::ctrl_status_type   status,
   output sdt_pkg::ctrl_cmd_type      cmd,
   output logic                       req_ready
);

   sdt_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sdt_pkg::ST_SWEEP: begin
            if (status.sweep_done) state_in = sdt_pkg::ST_IDLE;
         end
         sdt_pkg::ST_IDLE: begin
            if (status.req_valid) state_in = sdt_pkg::ST_EVAL;
         end
         sdt_pkg::ST_EVAL: begin
            unique case (status.action)
               sdt_pkg::ACT_STORE:  state_in = sdt_pkg::ST_IDLE;
               sdt_pkg::ACT_LOOKUP: state_in = sdt_pkg::ST_RESP;
               sdt_pkg::ACT_PATH:   state_in = status.last ? sdt_pkg::ST_DIV
                                                           : sdt_pkg::ST_IDLE;
               sdt_pkg::ACT_CLEAR:  state_in = sdt_pkg::ST_SWEEP;
               default:             state_in = sdt_pkg::ST_IDLE;
            endcase
         end
         sdt_pkg::ST_DIV: begin
            if (status.div_done) state_in = sdt_pkg::ST_RESP;
         end
         sdt_pkg::ST_RESP: begin
            if (status.out_free) state_in = sdt_pkg::ST_IDLE;
         end
         default: state_in = sdt_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         sdt_pkg::ST_SWEEP: cmd.sweep = 1'b1;
         sdt_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.take  = status.req_valid;
         end
         sdt_pkg::ST_EVAL:  cmd.eval = 1'b1;
         sdt_pkg::ST_DIV:   cmd = '0;
         sdt_pkg::ST_RESP:  cmd.load_out = status.out_free;
         default:           cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sdt_pkg::ST_SWEEP;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/core/symmetric_distance_table_path_mean_unit.sv
// symmetric_distance_table_path_mean_unit: top level, controller plus datapath
// depends on sdt_pkg, sdt_if, sdt_controller, sdt_datapath
//
//   channel   dir   modport        carries
//   req_bus   in    sdt_req_if     action, index pair, distance, last_in_path
//   rsp_bus   out   sdt_rsp_if     result_kind, found, value, overflow
//
// store, clear and inner path items pass through two steps: accept with table read, then evaluate
// a lookup then loads the response register
// the last path item then runs the divider and the response load
// clear table then runs a sweep over all N*(N+1)/2 entries (N = min(NUM_INDICES, 64)), also after reset
// one request at a time; a waiting response holds only a request that has a response
module symmetric_distance_table_path_mean_unit #(
   parameter int NUM_INDICES    = 64,
   parameter int MAX_PATH_PAIRS = 65535
) (
   input  logic       clock,
   input  logic       reset,
   sdt_req_if.sink    req_bus,
   sdt_rsp_if.source  rsp_bus
);

   sdt_pkg::ctrl_cmd_type    cmd;
   sdt_pkg::ctrl_status_type status;
   logic                     ready;

   sdt_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .status    (status),
      .cmd       (cmd),
      .req_ready (ready)
   );

   assign req_bus.ready = ready;

   sdt_datapath #(
      .NUM_INDICES    (NUM_INDICES),
      .MAX_PATH_PAIRS (MAX_PATH_PAIRS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_valid        (req_bus.valid),
      .req_action       (req_bus.action),
      .req_first_index  (req_bus.first_index),
      .req_second_index (req_bus.second_index),
      .req_distance     (req_bus.distance),
      .req_last_in_path (req_bus.last_in_path),
      .rsp_valid        (rsp_bus.valid),
      .rsp_ready        (rsp_bus.ready),
      .rsp_result_kind  (rsp_bus.result_kind),
      .rsp_found        (rsp_bus.found),
      .rsp_value        (rsp_bus.value),
      .rsp_overflow     (rsp_bus.overflow)
   );

endmodule

FILE: rtl/core/sdt_checker.sv
// sdt_checker: port-level assertions on the unit, bound to the top level
// depends on sdt_pkg
module sdt_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic                              rsp_result_kind,
   input logic                              rsp_found,
   input logic signed [sdt_pkg::DistW-1:0]  rsp_value,
   input logic                              rsp_overflow
);

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_lookup_no_ovf: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == sdt_pkg::RESULT_LOOKUP |-> !rsp_overflow)
      else $error("lookup response with overflow");

   a_path_not_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == sdt_pkg::RESULT_PATH |-> !rsp_found)
      else $error("path response with found set");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == sdt_pkg::RESULT_LOOKUP && !rsp_found
      |-> rsp_value == '0)
      else $error("lookup miss with nonzero value");

endmodule

bind symmetric_distance_table_path_mean_unit sdt_checker u_sdt_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_result_kind (rsp_bus.result_kind),
   .rsp_found       (rsp_bus.found),
   .rsp_value       (rsp_bus.value),
   .rsp_overflow    (rsp_bus.overflow)
);

FILE: tb/tb_symmetric_distance_table_path_mean_unit.sv
// testbench of symmetric_distance_table_path_mean_unit: directed table and random
// traffic, each response checked against a typed row's answer or a behavioral predictor
// depends on sdt_pkg, sdt_if and the unit itself
module tb_symmetric_distance_table_path_mean_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import sdt_pkg::*;

   localparam int Entries   = MaxIndices * (MaxIndices + 1) / 2;
   localparam int PairLimit = 65535;
   localparam int HoldCycles = 300;

   typedef struct packed {
      logic              kind;
      logic              found;
      logic [DistW-1:0]  value;
      logic              overflow;
   } table_answer_t;

   typedef struct packed {
      action_type        action;
      logic [IndexW-1:0] first;
      logic [IndexW-1:0] second;
      logic [DistW-1:0]  distance;
      logic              last;
      logic              typed;
      table_answer_t     answer;
      logic [1:0]        mode;
      logic              hold;
   } request_item_t;

   typedef struct packed {
      action_type        action;
      logic [IndexW-1:0] first;
      logic [IndexW-1:0] second;
      logic [DistW-1:0]  distance;
      logic              last;
      logic              typed;
      logic              found;
      logic [DistW-1:0]  value;
      logic              overflow;
   } directed_row_t;

   logic clock = 1'b0;
   logic reset;

   sdt_req_if req_bus ();
   sdt_rsp_if rsp_bus ();

   symmetric_distance_table_path_mean_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // expected table and path state
   logic [DistW-1:0]  distance_mem [0:Entries-1];
   bit                entry_valid [0:Entries-1];
   logic [IndexW-1:0] prev_index;
   bit                prev_seen;
   longint            path_total;
   int                pairs_counted;
   bit                pairs_overflowed;

   request_item_t     stim_q [$];
   table_answer_t     pending_answers [$];
   request_item_t     in_flight;
   table_answer_t     predicted;
   bit                produces;
   bit                hold_pulse;
   logic              hold_trigger;
   int                hold_left;
   logic [1:0]        cur_mode = 2'd0;
   int                mismatch_count = 0;
   int                pool_base = 0;
   int                send_idle_pct [4] = '{0, 59, 0, 28};
   int                recv_stall_pct [4] = '{0, 0, 59, 28};

   directed_row_t directed_rows [0:25] = '{
      '{ACT_LOOKUP, 6'd0,  6'd0,  32'h0000_0000, 1'b0, 1'b1, 1'b0, 32'h0000_0000, 1'b0},
      '{ACT_STORE,  6'd0,  6'd63, 32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0, 32'h0, 1'b0},
      '{ACT_LOOKUP, 6'd63, 6'd0,  32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 32'h7FFF_FFFF, 1'b0},
      '{ACT_STORE,  6'd63, 6'd63, 32'h8000_0000, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0},
      '{ACT_LOOKUP, 6'd63, 6'd63, 32'h0000_0000, 1'b0, 1'b1, 1'b1, 32'h8000_0000, 1'b0},
      '{ACT_STORE,  6'd20, 6'd10, 32'h0001_0000, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0},
      '{ACT_STORE,  6'd20, 6'd30, 32'h0002_8000, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0},
      '{ACT_PATH,   6'd10, 6'd63, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0},
      '{ACT_PATH,   6'd20, 6'd0,  32'h0000_0000, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0},
      '{ACT_LOOKUP, 6'd20, 6'd10, 32'h0000_0000, 1'b0, 1'b1, 1'b1, 32'h0001_0000, 1'b0},
      '{ACT_STORE,  6'd40, 6'd30, 32'hFFFF_FFFD, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0},
      '{ACT_PATH,   6'd30, 6'd0,  32'h0000_0000, 1'b1, 1'b1, 1'b0, 32'h0001_C000, 1'b0},
      '{ACT_PATH,   6'd5,  6'd0,  32'h0000_0000, 1'b1, 1'b1, 1'b0, 32'h0000_0000, 1'b0},
      '{ACT_PATH,   6'd0,  6'd0,  32'h0000_0000, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0},
      '{ACT_PATH,   6'd63, 6'd0,  32'h0000_0000, 1'b1, 1'b1, 1'b0, 32'h7FFF_FFFF, 1'b0},
      '{ACT_PATH,   6'd30, 6'd0,  32'h0000_0000, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0},
      '{ACT_PATH,   6'd40, 6'd0,  32'h0000_0000, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0},
      '{ACT_PATH,   6'd40, 6'd0,  32'h0000_0000, 1'b1, 1'b1, 1'b0, 32'hFFFF_FFFD, 1'b0},
      '{ACT_PATH,   6'd63, 6'd0,  32'h0000_0000, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0},
      '{ACT_PATH,   6'd63, 6'd0,  32'h0000_0000, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0},
      '{ACT_PATH,   6'd0,  6'd0,  32'h0000_0000, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0},
      '{ACT_PATH,   6'd63, 6'd0,  32'h0000_0000, 1'b1, 1'b0, 1'b0, 32'h0, 1'b0},
      '{ACT_PATH,   6'd20, 6'd0,  32'h0000_0000, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0},
      '{ACT_CLEAR,  6'd63, 6'd63, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 32'h0, 1'b0},
      '{ACT_PATH,   6'd30, 6'd0,  32'h0000_0000, 1'b1, 1'b1, 1'b0, 32'h0000_0000, 1'b0},
      '{ACT_LOOKUP, 6'd0,  6'd63, 32'h0000_0000, 1'b0, 1'b1, 1'b0, 32'h0000_0000, 1'b0}
   };

   function automatic int tri_addr(logic [IndexW-1:0] a, logic [IndexW-1:0] b);
      int lo;
      int hi;
      lo = (a < b) ? int'(a) : int'(b);
      hi = (a < b) ? int'(b) : int'(a);
      return hi * (hi + 1) / 2 + lo;
   endfunction

   task automatic predict_table_answer(input request_item_t item, output bit has_answer,
                                       output table_answer_t answer);
      int     addr;
      longint mean;
      has_answer = 1'b0;
      answer = '0;
      case (item.action)
         ACT_STORE: begin
            addr = tri_addr(item.first, item.second);
            distance_mem[addr] = item.distance;
            entry_valid[addr] = 1'b1;
         end
         ACT_LOOKUP: begin
            addr = tri_addr(item.first, item.second);
            has_answer = 1'b1;
            answer.kind = RESULT_LOOKUP;
            answer.found = entry_valid[addr];
            answer.value = entry_valid[addr] ? distance_mem[addr] : '0;
         end
         ACT_CLEAR: begin
            foreach (entry_valid[k]) entry_valid[k] = 1'b0;
         end
         default: begin
            addr = tri_addr(prev_index, item.first);
            if (prev_seen && entry_valid[addr]) begin
               if (pairs_counted >= PairLimit) begin
                  pairs_overflowed = 1'b1;
               end else begin
                  path_total += longint'($signed(distance_mem[addr]));
                  pairs_counted++;
               end
            end
            prev_index = item.first;
            prev_seen = 1'b1;
            if (item.last) begin
               mean = path_total;
               if (pairs_counted > 1) mean = path_total / longint'(pairs_counted);
               has_answer = 1'b1;
               answer.kind = RESULT_PATH;
               answer.value = mean[DistW-1:0];
               answer.overflow = pairs_overflowed;
               prev_index = '0;
               prev_seen = 1'b0;
               path_total = 0;
               pairs_counted = 0;
               pairs_overflowed = 1'b0;
            end
         end
      endcase
   endtask

   task automatic report_mismatch(string what, logic [DistW-1:0] got, logic [DistW-1:0] want);
      $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   task automatic check_response();
      table_answer_t want;
      if (pending_answers.size() == 0) begin
         report_mismatch("response with nothing pending", rsp_bus.value, '0);
      end else begin
         want = pending_answers.pop_front();
         if (rsp_bus.result_kind !== want.kind)
            report_mismatch("result_kind", rsp_bus.result_kind, want.kind);
         if (rsp_bus.found !== want.found)
            report_mismatch("found", rsp_bus.found, want.found);
         if (rsp_bus.value !== want.value)
            report_mismatch("value", rsp_bus.value, want.value);
         if (rsp_bus.overflow !== want.overflow)
            report_mismatch("overflow", rsp_bus.overflow, want.overflow);
      end
   endtask

   task automatic push_request(action_type action, logic [IndexW-1:0] a,
                               logic [IndexW-1:0] b, logic [DistW-1:0] d, logic last,
                               logic [1:0] mode, logic hold);
      request_item_t item;
      item = '0;
      item.action = action;
      item.first = a;
      item.second = b;
      item.distance = d;
      item.last = last;
      item.mode = mode;
      item.hold = hold;
      stim_q.insert(stim_q.size(), item);
   endtask

   function automatic logic [IndexW-1:0] pick_index();
      if ($urandom_range(99) < 85) return IndexW'(pool_base + $urandom_range(7));
      return IndexW'($urandom_range(MaxIndices - 1));
   endfunction

   function automatic logic [DistW-1:0] pick_distance();
      int sel;
      sel = $urandom_range(99);
      if (sel < 60) return $urandom;
      if (sel < 80) return DistW'($urandom_range(32'h3FFFF) - 32'h20000);
      case ($urandom_range(4))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'hFFFF_FFFF;
         3: return 32'h0000_0001;
         default: return 32'h0000_0000;
      endcase
   endfunction

   task automatic add_random_traffic(int count, logic [1:0] mode, int hold_at);
      int made;
      int sel;
      int len;
      made = 0;
      while (made < count) begin
         if (made % 40 == 0) pool_base = $urandom_range(MaxIndices - 8);
         sel = $urandom_range(99);
         if (sel < 40) begin
            // a path, sometimes interrupted or left open
            len = $urandom_range(1, 6);
            for (int k = 0; k < len; k++) begin
               if ($urandom_range(9) == 0) begin
                  push_request(ACT_LOOKUP, pick_index(), pick_index(), $urandom,
                               1'($urandom), mode, made == hold_at);
                  made++;
               end
               push_request(ACT_PATH, pick_index(), IndexW'($urandom), pick_distance(),
                            (k == len - 1) && ($urandom_range(19) != 0), mode,
                            made == hold_at);
               made++;
            end
         end else if (sel < 72) begin
            push_request(ACT_STORE, pick_index(), pick_index(), pick_distance(),
                         1'($urandom), mode, made == hold_at);
            made++;
         end else if (sel < 98) begin
            push_request(ACT_LOOKUP, pick_index(), pick_index(), $urandom, 1'($urandom),
                         mode, made == hold_at);
            made++;
         end else begin
            push_request(ACT_CLEAR, IndexW'($urandom), IndexW'($urandom), $urandom,
                         1'($urandom), mode, made == hold_at);
            made++;
         end
      end
   endtask

   // request side and response checking share one process so ordering is fixed
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         hold_trigger <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) check_response();
         if (req_bus.valid && req_bus.ready) begin
            predict_table_answer(in_flight, produces, predicted);
            if (produces)
               pending_answers.insert(pending_answers.size(),
                                      in_flight.typed ? in_flight.answer : predicted);
         end
         hold_pulse = 1'b0;
         if (!req_bus.valid || req_bus.ready) begin
            if (stim_q.size() != 0 &&
                $urandom_range(99) >= send_idle_pct[stim_q[0].mode]) begin
               in_flight = stim_q.pop_front();
               req_bus.valid <= 1'b1;
               req_bus.action <= in_flight.action;
               req_bus.first_index <= in_flight.first;
               req_bus.second_index <= in_flight.second;
               req_bus.distance <= in_flight.distance;
               req_bus.last_in_path <= in_flight.last;
               cur_mode <= in_flight.mode;
               hold_pulse = in_flight.hold;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
         hold_trigger <= hold_pulse;
      end
   end

   // response side backpressure, including one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         hold_left <= 0;
      end else if (hold_trigger) begin
         rsp_bus.ready <= 1'b0;
         hold_left <= HoldCycles;
      end else if (hold_left != 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct[cur_mode]);
      end
   end

   initial begin
      directed_row_t row;
      request_item_t item;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.action = ACT_STORE;
      req_bus.first_index = '0;
      req_bus.second_index = '0;
      req_bus.distance = '0;
      req_bus.last_in_path = 1'b0;
      rsp_bus.ready = 1'b0;
      hold_trigger = 1'b0;

      foreach (directed_rows[r]) begin
         row = directed_rows[r];
         item = '0;
         item.action = row.action;
         item.first = row.first;
         item.second = row.second;
         item.distance = row.distance;
         item.last = row.last;
         item.typed = row.typed;
         item.answer.kind = (row.action == ACT_LOOKUP) ? RESULT_LOOKUP : RESULT_PATH;
         item.answer.found = row.found;
         item.answer.value = row.value;
         item.answer.overflow = row.overflow;
         stim_q.insert(stim_q.size(), item);
      end

      add_random_traffic(250, 2'd0, 30);
      add_random_traffic(250, 2'd1, -1);
      add_random_traffic(250, 2'd2, -1);
      add_random_traffic(250, 2'd3, -1);

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      do @(negedge clock);
      while (stim_q.size() != 0 || req_bus.valid || pending_answers.size() != 0);
      repeat (80) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #15_000_000;
      $display("status: fail");
      $finish;
   end

endmodule
